// ----- rtl/core/cwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared widths, register indexes and reset values for the coin change
// way counter.
// ----------------------------------------------------------------------------
package cwc_pkg;

   localparam int AMT_W          = 15;
   localparam int AMT_MAX_VAL    = 32767;
   localparam int WAYS_W         = 64;
   localparam int COIN_W         = 10;
   localparam int NREGS          = 4;
   localparam int REG_IDX_W      = 2;

   localparam int AMOUNT_MAX_DEF = 32767;
   localparam int COIN_COUNT_DEF = 5;

   localparam logic [REG_IDX_W-1:0] REG_COIN_SECOND = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_COIN_THIRD  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_COIN_FOURTH = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_COIN_FIFTH  = 2'd3;

   localparam logic [COIN_W-1:0] COIN_SECOND_RST = 10'd5;
   localparam logic [COIN_W-1:0] COIN_THIRD_RST  = 10'd10;
   localparam logic [COIN_W-1:0] COIN_FOURTH_RST = 10'd25;
   localparam logic [COIN_W-1:0] COIN_FIFTH_RST  = 10'd50;

   localparam logic [WAYS_W-1:0] WAYS_ALL_ONES = {WAYS_W{1'b1}};

   typedef logic [WAYS_W-1:0] ways_type;

endpackage

// ----- rtl/core/cwc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module cwc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/coin_change_way_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coin_change_way_counter
// Counts the ways to make an amount from one unit coin and configurable coins,
// extending a dynamic-programming table in RAM only as far as each request
// needs it.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_amount
//  rsp      out        rsp_valid / rsp_stall  rsp_ways, rsp_saturated
//  csr      in         csr_wr_en              csr_index, csr_wr_data
//
//  One word at a time: zero or above AMOUNT_MAX goes straight to output, a row
//  already in the table reads its answer first, else COIN_COUNT-1 writes per
//  new row (one table write per cycle) fill the table before the answer read.
//  Reset is synchronous; it restores the coin values and empties the table.
//  A stalled result holds in the output register; rsp_stall only delays the
//  return to idle.
// ----------------------------------------------------------------------------
module coin_change_way_counter
   import cwc_pkg::*;
#(
   parameter int AMOUNT_MAX = AMOUNT_MAX_DEF,
   parameter int COIN_COUNT = COIN_COUNT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [AMT_W-1:0]     req_amount,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WAYS_W-1:0]    rsp_ways,
   output logic                 rsp_saturated,
   input  logic                 csr_wr_en,
   input  logic [REG_IDX_W-1:0] csr_index,
   input  logic [COIN_W-1:0]    csr_wr_data
);

   localparam int NCOLS   = COIN_COUNT - 1;
   localparam int ROW_MAX = (AMOUNT_MAX < AMT_MAX_VAL) ? AMOUNT_MAX : AMT_MAX_VAL;
   localparam int DEPTH   = (ROW_MAX + 1) * NCOLS;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = (NCOLS > 1) ? $clog2(NCOLS) : 1;

   localparam logic [CW-1:0] LAST_COL = CW'(NCOLS - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_FILL   = 2'd1;
   localparam logic [1:0] S_ANS_RD = 2'd2;
   localparam logic [1:0] S_OUT    = 2'd3;

   localparam logic [1:0] RES_ZERO = 2'd0;
   localparam logic [1:0] RES_ONE  = 2'd1;
   localparam logic [1:0] RES_MEM  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [AMT_W-1:0]  target_ff, target_in;
   logic [1:0]        kind_ff, kind_in;
   logic [AMT_W-1:0]  filled_ff, filled_in;
   logic [AMT_W-1:0]  row_ff, row_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [CW-1:0]     col_ff, col_in;
   logic              issue_on_ff, issue_on_in;
   logic [COIN_W-1:0] coin_ff [NREGS];
   logic [COIN_W-1:0] coin_in [NREGS];

   logic              b_valid_ff, b_valid_in;
   logic              b_use_ff, b_use_in;
   logic              b_one_ff, b_one_in;
   logic              b_first_ff, b_first_in;
   logic              b_fwd_ff, b_fwd_in;
   logic [AW-1:0]     b_addr_ff, b_addr_in;
   ways_type          fwd_data_ff, fwd_data_in;
   ways_type          prev_ff, prev_in;

   logic              rsp_valid_ff, rsp_valid_in;
   ways_type          rsp_ways_ff, rsp_ways_in;
   logic              rsp_sat_ff, rsp_sat_in;

   logic [COIN_W-1:0] coin_sel;
   logic              issue;
   logic              hit;
   logic              src_one;
   logic [AW-1:0]     src_addr;
   logic [AW-1:0]     ans_addr;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   ways_type          ram_rd_data;
   ways_type          prev_sel;
   ways_type          addend;
   logic [WAYS_W:0]   sum_wide;
   ways_type          wr_val;
   ways_type          res_ways;
   logic              req_take;
   logic              out_free;

   cwc_ram #(
      .WIDTH (WAYS_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data (wr_val),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // coin value of the column being issued; coins past the fifth are 1
   always_comb begin
      coin_sel = COIN_W'(1);
      for (int k = 0; k < NREGS; k++) begin
         if (k < NCOLS && col_ff == CW'(k)) begin
            coin_sel = coin_ff[k];
         end
      end
   end

   assign issue    = (state_ff == S_FILL) && issue_on_ff;
   assign hit      = (coin_sel != '0) && (32'(row_ff) >= 32'(coin_sel));
   assign src_one  = (32'(row_ff) == 32'(coin_sel));
   assign src_addr = base_ff - AW'(AW'(coin_sel) * AW'(NCOLS)) + AW'(col_ff);
   assign ans_addr = AW'(AW'(target_ff) * AW'(NCOLS)) + AW'(NCOLS - 1);

   assign ram_rd_en   = (issue && hit && !src_one) || (state_ff == S_ANS_RD);
   assign ram_rd_addr = (state_ff == S_ANS_RD) ? ans_addr : src_addr;

   // column update: previous column plus the entry one coin back
   always_comb begin
      prev_sel = b_first_ff ? WAYS_W'(1) : prev_ff;
      if (!b_use_ff) begin
         addend = '0;
      end else if (b_one_ff) begin
         addend = WAYS_W'(1);
      end else if (b_fwd_ff) begin
         addend = fwd_data_ff;
      end else begin
         addend = ram_rd_data;
      end
      sum_wide = {1'b0, prev_sel} + {1'b0, addend};
      wr_val   = sum_wide[WAYS_W] ? WAYS_ALL_ONES : sum_wide[WAYS_W-1:0];
   end

   always_comb begin
      case (kind_ff)
         RES_ZERO: res_ways = '0;
         RES_ONE:  res_ways = WAYS_W'(1);
         RES_MEM:  res_ways = ram_rd_data;
         default:  res_ways = '0;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      kind_in      = kind_ff;
      filled_in    = filled_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      col_in       = col_ff;
      issue_on_in  = issue_on_ff;
      coin_in      = coin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ways_in  = rsp_ways_ff;
      rsp_sat_in   = rsp_sat_ff;

      b_valid_in   = issue;
      b_use_in     = hit;
      b_one_in     = src_one;
      b_first_in   = (col_ff == '0);
      b_fwd_in     = ram_rd_en && b_valid_ff && (ram_rd_addr == b_addr_ff);
      b_addr_in    = base_ff + AW'(col_ff);
      fwd_data_in  = wr_val;
      prev_in      = b_valid_ff ? wr_val : prev_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               target_in = req_amount;
               if (32'(req_amount) > 32'(AMOUNT_MAX)) begin
                  kind_in  = RES_ZERO;
                  state_in = S_OUT;
               end else if (req_amount == '0) begin
                  kind_in  = RES_ONE;
                  state_in = S_OUT;
               end else if (req_amount <= filled_ff) begin
                  kind_in  = RES_MEM;
                  state_in = S_ANS_RD;
               end else begin
                  kind_in     = RES_MEM;
                  row_in      = AMT_W'(filled_ff + 1'b1);
                  base_in     = AW'(AW'(AMT_W'(filled_ff + 1'b1)) * AW'(NCOLS));
                  col_in      = '0;
                  issue_on_in = 1'b1;
                  state_in    = S_FILL;
               end
            end
         end
         S_FILL: begin
            if (issue) begin
               if (col_ff == LAST_COL) begin
                  col_in  = '0;
                  row_in  = AMT_W'(row_ff + 1'b1);
                  base_in = AW'(base_ff + AW'(NCOLS));
                  if (row_ff == target_ff) begin
                     issue_on_in = 1'b0;
                  end
               end else begin
                  col_in = CW'(col_ff + 1'b1);
               end
            end else if (!b_valid_ff) begin
               filled_in = target_ff;
               state_in  = S_ANS_RD;
            end
         end
         S_ANS_RD: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ways_in  = res_ways;
               rsp_sat_in   = (res_ways == WAYS_ALL_ONES);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         case (csr_index)
            REG_COIN_SECOND: coin_in[0] = csr_wr_data;
            REG_COIN_THIRD:  coin_in[1] = csr_wr_data;
            REG_COIN_FOURTH: coin_in[2] = csr_wr_data;
            REG_COIN_FIFTH:  coin_in[3] = csr_wr_data;
            default: ;
         endcase
         filled_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filled_ff    <= '0;
         issue_on_ff  <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         coin_ff[0]   <= COIN_SECOND_RST;
         coin_ff[1]   <= COIN_THIRD_RST;
         coin_ff[2]   <= COIN_FOURTH_RST;
         coin_ff[3]   <= COIN_FIFTH_RST;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         issue_on_ff  <= issue_on_in;
         b_valid_ff   <= b_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         coin_ff      <= coin_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff   <= target_in;
      kind_ff     <= kind_in;
      row_ff      <= row_in;
      base_ff     <= base_in;
      col_ff      <= col_in;
      b_use_ff    <= b_use_in;
      b_one_ff    <= b_one_in;
      b_first_ff  <= b_first_in;
      b_fwd_ff    <= b_fwd_in;
      b_addr_ff   <= b_addr_in;
      fwd_data_ff <= fwd_data_in;
      prev_ff     <= prev_in;
      rsp_ways_ff <= rsp_ways_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ways      = rsp_ways_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule

// ----- rtl/core/cwc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwc_checker
// Port-level checks for the coin change way counter, bound to the top level.
// ----------------------------------------------------------------------------
module cwc_checker
   import cwc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [WAYS_W-1:0]    rsp_ways,
   input logic                 rsp_saturated
);

   // flag tracks the saturation value
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_saturated == (rsp_ways == WAYS_ALL_ONES)))
      else $error("saturated flag disagrees with ways");

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ways) && $stable(rsp_saturated))
      else $error("stalled result word changed");

   // one word in flight: stall right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while busy");

   // come out of reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind coin_change_way_counter cwc_checker u_cwc_checker (.*);

// ----- tb/coin_change_way_counter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coin_change_way_counter_tb
// Sends amounts to the way counter under several coin settings. A
// scoreboard keeps its own copy of the way table and checks every result
// word in order. Random idling on both channels exercises the handshakes.
// ----------------------------------------------------------------------------
module coin_change_way_counter_tb;
   import cwc_pkg::*;

   typedef struct packed {
      ways_type ways;
      logic     saturated;
   } count_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [AMT_W-1:0]     req_amount = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WAYS_W-1:0]    rsp_ways;
   logic                 rsp_saturated;
   logic                 csr_wr_en = 1'b0;
   logic [REG_IDX_W-1:0] csr_index = '0;
   logic [COIN_W-1:0]    csr_wr_data = '0;

   logic [AMT_W-1:0] amounts_to_send [$];
   count_word_type   expected_counts [$];
   int               mismatches = 0;
   bit               calm = 1'b0;

   // way table: one column per coin prefix beyond the unit coin
   bit [WAYS_W-1:0]  way_tab [0:AMT_MAX_VAL][NREGS];
   int unsigned      rows_ready;
   logic [COIN_W-1:0] coin_val [NREGS];

   coin_change_way_counter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_amount    (req_amount),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ways      (rsp_ways),
      .rsp_saturated (rsp_saturated),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic ways_type sat_sum(input ways_type a, input ways_type b);
      ways_type s;
      s = a + b;
      return (s < a) ? WAYS_ALL_ONES : s;
   endfunction

   function automatic void clear_table();
      for (int j = 0; j < NREGS; j++) way_tab[0][j] = 1;
      rows_ready = 0;
   endfunction

   function automatic void queue_amount(input logic [AMT_W-1:0] amt);
      amounts_to_send = {amounts_to_send, amt};
   endfunction

   function automatic count_word_type count_ways(input logic [AMT_W-1:0] amt);
      count_word_type res;
      ways_type       left;
      ways_type       acc;
      int unsigned    c;
      while (rows_ready < amt) begin
         rows_ready++;
         left = 1;
         for (int j = 0; j < NREGS; j++) begin
            c = coin_val[j];
            acc = left;
            if (c != 0 && rows_ready >= c)
               acc = sat_sum(acc, way_tab[rows_ready - c][j]);
            way_tab[rows_ready][j] = acc;
            left = acc;
         end
      end
      res.ways = way_tab[amt][NREGS-1];
      res.saturated = (res.ways == WAYS_ALL_ONES);
      return res;
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      logic sent;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sent = req_valid && !req_stall;
         if (sent) expected_counts = {expected_counts, count_ways(req_amount)};
         if (req_valid && !sent) begin
            // hold the stalled word
         end else if (amounts_to_send.size() != 0 &&
                      (calm || $urandom_range(0, 99) >= 7)) begin
            req_amount <= amounts_to_send.pop_front();
            req_valid  <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
      end
   end

   // result monitor
   always @(posedge clock) begin : check_rsp
      count_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_counts.size() == 0) begin
            $error("unexpected result word: ways %0d", rsp_ways);
            mismatches++;
         end else begin
            want = expected_counts.pop_front();
            if (rsp_ways !== want.ways) begin
               $error("ways mismatch: expected %0d, actual %0d", want.ways, rsp_ways);
               mismatches++;
            end
            if (rsp_saturated !== want.saturated) begin
               $error("saturated mismatch: expected %0d, actual %0d",
                      want.saturated, rsp_saturated);
               mismatches++;
            end
         end
      end
   end

   task automatic write_coin(input logic [REG_IDX_W-1:0] idx,
                             input logic [COIN_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      coin_val[idx] = val;
      clear_table();
   endtask

   task automatic set_coins(input logic [COIN_W-1:0] c1, input logic [COIN_W-1:0] c2,
                            input logic [COIN_W-1:0] c3, input logic [COIN_W-1:0] c4);
      write_coin(REG_COIN_SECOND, c1);
      write_coin(REG_COIN_THIRD, c2);
      write_coin(REG_COIN_FOURTH, c3);
      write_coin(REG_COIN_FIFTH, c4);
      repeat (4) @(posedge clock);
   endtask

   // mostly spread over the span, the rest on the low rows
   task automatic add_random(input int count, input int unsigned span);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 75)
            queue_amount(AMT_W'($urandom_range(0, span)));
         else
            queue_amount(AMT_W'($urandom_range(0, 63)));
      end
   endtask

   task automatic wait_idle();
      while (amounts_to_send.size() != 0 || req_valid || expected_counts.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      coin_val[REG_COIN_SECOND] = COIN_SECOND_RST;
      coin_val[REG_COIN_THIRD]  = COIN_THIRD_RST;
      coin_val[REG_COIN_FOURTH] = COIN_FOURTH_RST;
      coin_val[REG_COIN_FIFTH]  = COIN_FIFTH_RST;
      clear_table();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // reset coins: row zero, coin edges, alternating bits, full table
      amounts_to_send = '{15'd0, 15'd1, 15'd4, 15'd5, 15'd6, 15'd9, 15'd10,
                          15'd11, 15'd25, 15'd50, 15'd51, 15'd99, 15'd100,
                          15'd10922, 15'd21845, 15'd32767, 15'd16384, 15'd1, 15'd0};
      wait_idle();
      add_random(10, AMT_MAX_VAL);
      wait_idle();

      // largest coins, no idling
      set_coins(10'd1023, 10'd1023, 10'd1023, 10'd1023);
      calm = 1'b1;
      queue_amount(15'd1022);
      queue_amount(15'd1023);
      queue_amount(15'd2046);
      add_random(15, 3000);
      queue_amount(15'd32767);
      wait_idle();
      calm = 1'b0;

      // smallest coins
      set_coins(10'd1, 10'd1, 10'd1, 10'd1);
      add_random(15, 2000);
      queue_amount(15'd32767);
      wait_idle();

      // zero coin values
      set_coins(10'd0, 10'd3, 10'd0, 10'd7);
      queue_amount(15'd0);
      queue_amount(15'd7);
      add_random(15, 1500);
      wait_idle();

      repeat (2) begin
         set_coins(COIN_W'($urandom_range(0, 1023)), COIN_W'($urandom_range(0, 1023)),
                   COIN_W'($urandom_range(0, 1023)), COIN_W'($urandom_range(0, 1023)));
         add_random(10, 4000);
         wait_idle();
      end

      if (mismatches == 0 && expected_counts.size() == 0) begin
         $display("coin_change_way_counter_tb OK");
      end else begin
         $display("coin_change_way_counter_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #32_000_000;
      $display("coin_change_way_counter_tb NOT OK");
      $finish;
   end

endmodule
